[src/buddy_page_allocator_macros.svh]
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define BPA_ASSERT_IMPLIES(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("assertion failed");
`define BPA_ASSERT_NEXT(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define BPA_ASSERT_IMPLIES(label, ck, rn, cond, prop)
`define BPA_ASSERT_NEXT(label, ck, rn, cond, prop)
`endif
`endif

[src/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// shared codes and field widths of the buddy page allocator
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
    localparam int FRAME_FIELD_W = 10;
    localparam int ORDER_FIELD_W = 3;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FAIL = 1'b1
    } status_t;
endpackage
`default_nettype wire

[src/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// frame table: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_ram #(
    parameter int DW    = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DW-1:0]            rd_data
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

[src/bpa_alu.sv]
// ----------------------------------------------------------------------------
// bpa_alu
// shared buddy unit: buddy frame, lower and upper head, range check
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_alu #(
    parameter int FW          = 11,
    parameter int OW          = 3,
    parameter int FRAME_COUNT = 1024
) (
    input  wire logic [FW-1:0] base,
    input  wire logic [OW-1:0] shift,
    output logic      [FW-1:0] buddy,
    output logic      [FW-1:0] lo,
    output logic      [FW-1:0] hi,
    output logic               beyond
);
    logic [FW-1:0] bit_mask;

    always_comb
    begin
        bit_mask = FW'(1) << shift;
        buddy    = base ^ bit_mask;
        lo       = (buddy < base) ? buddy : base;
        hi       = (buddy < base) ? base : buddy;
        beyond   = 32'(buddy) >= 32'(FRAME_COUNT);
    end
endmodule
`default_nettype wire

[src/buddy_page_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator
// buddy allocator over a page frame table with doubly linked free lists
//
//   channel   handshake          payload
//   request   start / busy       command, req_order, frame_number
//   result    done (one cycle)   status, result_frame, result_order
//
// after reset a clearing pass writes every entry of the frame table;
// busy is high meanwhile
// an allocate scans the free lists upward, removes the block found and splits it down
// a free merges the frame with each free buddy of equal order, then appends it
// to the free list of its final order
// every step makes at most one write and one read of the frame table
// the result beat cannot be stalled; busy falls with it
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module buddy_page_allocator #(
    parameter int FRAME_COUNT = 1024,
    parameter int TOP_ORDER   = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               command,
    input  wire logic [bpa_pkg::ORDER_FIELD_W-1:0]  req_order,
    input  wire logic [bpa_pkg::FRAME_FIELD_W-1:0]  frame_number,
    output logic                                    done,
    output logic                                    status,
    output logic      [bpa_pkg::FRAME_FIELD_W-1:0]  result_frame,
    output logic      [bpa_pkg::ORDER_FIELD_W-1:0]  result_order
);
    import bpa_pkg::*;

    localparam int FW         = $clog2(FRAME_COUNT + 1);
    localparam int AW         = $clog2(FRAME_COUNT);
    localparam int OW         = $clog2(TOP_ORDER + 2);
    localparam int LIST_COUNT = TOP_ORDER + 1;
    localparam int LW         = $clog2(LIST_COUNT);
    localparam int TOP_SIZE   = 1 << TOP_ORDER;
    localparam int NUM_TOP    = FRAME_COUNT / TOP_SIZE;

    localparam logic [FW-1:0] NONE_F    = FW'(FRAME_COUNT);
    localparam logic [OW-1:0] NONE_O    = OW'(TOP_ORDER + 1);
    localparam logic [OW-1:0] TOP_O     = OW'(TOP_ORDER);
    localparam logic [FW-1:0] TOP_FIRST = (NUM_TOP > 0) ? '0 : NONE_F;
    localparam logic [FW-1:0] TOP_LAST  =
        (NUM_TOP > 0) ? FW'((NUM_TOP - 1) * TOP_SIZE) : NONE_F;
    localparam logic [AW-1:0] CLR_LAST  = AW'(FRAME_COUNT - 1);

    typedef struct packed {
        logic [FW-1:0] nxt;
        logic [FW-1:0] prv;
        logic [OW-1:0] ord;
        logic          fr;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FAIL, S_SCAN, S_RM_RD, S_RM_GOT, S_RM_PWR, S_RM_N,
        S_RM_NWR, S_RM_F, S_SPLIT, S_SET_T, S_AP_W, S_AP_TWR, S_FR_CHK,
        S_MG_TEST, S_MG_CHK, S_MG_ABS, S_FR_DONE
    } state_t;

    state_t        state_reg;
    logic          cmd_reg;
    logic [OW-1:0] k_reg;
    logic [OW-1:0] i_reg;
    logic [FW-1:0] f_reg;
    logic [FW-1:0] op_f_reg;
    logic [OW-1:0] op_k_reg;
    logic [FW-1:0] tail_reg;
    entry_t        ent_reg;
    logic [AW-1:0] clr_reg;
    logic [FW-1:0] first_reg [LIST_COUNT];
    logic [FW-1:0] last_reg  [LIST_COUNT];
    logic          done_reg;
    logic          status_reg;
    logic [FRAME_FIELD_W-1:0] rframe_reg;
    logic [ORDER_FIELD_W-1:0] rorder_reg;

    logic          wr_en;
    logic [FW-1:0] wr_frame;
    entry_t        wr_ent;
    logic          rd_en;
    logic [FW-1:0] rd_frame;
    logic [EW-1:0] rd_word;
    entry_t        rd_ent;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic [LW-1:0] lidx;
    logic [FW-1:0] first_sel;
    logic [FW-1:0] last_sel;
    logic [OW-1:0] alu_shift;
    logic [FW-1:0] buddy;
    logic [FW-1:0] lo;
    logic [FW-1:0] hi;
    logic          beyond;
    logic [31:0]   ci;
    logic          clr_head;
    entry_t        clr_ent;
    state_t        ret_state;

    bpa_ram #(
        .DW    (EW),
        .DEPTH (FRAME_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    bpa_alu #(
        .FW          (FW),
        .OW          (OW),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_alu (
        .base   (f_reg),
        .shift  (alu_shift),
        .buddy  (buddy),
        .lo     (lo),
        .hi     (hi),
        .beyond (beyond)
    );

    assign rd_ent  = entry_t'(rd_word);
    assign wr_addr = wr_frame[AW-1:0];
    assign rd_addr = rd_frame[AW-1:0];

    always_comb
    begin
        lidx      = (state_reg == S_SCAN) ? LW'(i_reg) : LW'(op_k_reg);
        first_sel = first_reg[lidx];
        last_sel  = last_reg[lidx];
        alu_shift = (cmd_reg == CMD_ALLOC) ? (i_reg - OW'(1)) : k_reg;
        ret_state = (cmd_reg == CMD_ALLOC) ? S_SPLIT : S_FR_DONE;

        ci           = 32'(clr_reg);
        clr_head     = ((ci % TOP_SIZE) == 0) && (ci + TOP_SIZE <= FRAME_COUNT);
        clr_ent.nxt  = (clr_head && (ci + 2 * TOP_SIZE <= FRAME_COUNT)) ?
                       FW'(ci + TOP_SIZE) : NONE_F;
        clr_ent.prv  = (clr_head && (ci >= TOP_SIZE)) ? FW'(ci - TOP_SIZE) : NONE_F;
        clr_ent.ord  = clr_head ? TOP_O : NONE_O;
        clr_ent.fr   = 1'b1;
    end

    // frame table access of each step
    always_comb
    begin
        wr_en    = 1'b0;
        wr_frame = '0;
        wr_ent   = rd_ent;
        rd_en    = 1'b0;
        rd_frame = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_frame = FW'(clr_reg);
                wr_ent   = clr_ent;
            end
            S_IDLE:
            begin
                rd_en    = 1'b1;
                rd_frame = FW'(frame_number);
            end
            S_RM_RD:
            begin
                rd_en    = 1'b1;
                rd_frame = op_f_reg;
            end
            S_RM_GOT:
            begin
                rd_en    = rd_ent.prv != NONE_F;
                rd_frame = rd_ent.prv;
            end
            S_RM_PWR:
            begin
                wr_en      = 1'b1;
                wr_frame   = ent_reg.prv;
                wr_ent     = rd_ent;
                wr_ent.nxt = ent_reg.nxt;
            end
            S_RM_N:
            begin
                rd_en    = ent_reg.nxt != NONE_F;
                rd_frame = ent_reg.nxt;
            end
            S_RM_NWR:
            begin
                wr_en      = 1'b1;
                wr_frame   = ent_reg.nxt;
                wr_ent     = rd_ent;
                wr_ent.prv = ent_reg.prv;
            end
            S_RM_F:
            begin
                wr_en    = 1'b1;
                wr_frame = op_f_reg;
                wr_ent   = '{nxt: NONE_F, prv: NONE_F, ord: ent_reg.ord, fr: 1'b0};
            end
            S_SET_T:
            begin
                wr_en    = 1'b1;
                wr_frame = f_reg;
                wr_ent   = '{nxt: NONE_F, prv: NONE_F, ord: k_reg, fr: 1'b0};
            end
            S_AP_W:
            begin
                wr_en    = 1'b1;
                wr_frame = op_f_reg;
                wr_ent   = '{nxt: NONE_F, prv: last_sel, ord: op_k_reg, fr: 1'b1};
                rd_en    = last_sel != NONE_F;
                rd_frame = last_sel;
            end
            S_AP_TWR:
            begin
                wr_en      = 1'b1;
                wr_frame   = tail_reg;
                wr_ent     = rd_ent;
                wr_ent.nxt = op_f_reg;
            end
            S_MG_TEST:
            begin
                rd_en    = (k_reg != TOP_O) && !beyond;
                rd_frame = buddy;
            end
            S_MG_ABS:
            begin
                wr_en    = 1'b1;
                wr_frame = hi;
                wr_ent   = '{nxt: NONE_F, prv: NONE_F, ord: NONE_O, fr: 1'b0};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            rframe_reg <= '0;
            rorder_reg <= '0;
            for (int n = 0; n < LIST_COUNT; n++)
            begin
                first_reg[n] <= (n == TOP_ORDER) ? TOP_FIRST : NONE_F;
                last_reg[n]  <= (n == TOP_ORDER) ? TOP_LAST : NONE_F;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= command;
                        if (command == CMD_ALLOC)
                        begin
                            if (32'(req_order) > TOP_ORDER)
                            begin
                                state_reg <= S_FAIL;
                            end
                            else
                            begin
                                k_reg     <= OW'(req_order);
                                i_reg     <= OW'(req_order);
                                state_reg <= S_SCAN;
                            end
                        end
                        else if (32'(frame_number) >= FRAME_COUNT)
                        begin
                            state_reg <= S_FAIL;
                        end
                        else
                        begin
                            f_reg     <= FW'(frame_number);
                            state_reg <= S_FR_CHK;
                        end
                    end
                end
                S_FAIL:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= STATUS_FAIL;
                    rframe_reg <= '0;
                    rorder_reg <= '0;
                    state_reg  <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (first_sel != NONE_F)
                    begin
                        f_reg     <= first_sel;
                        op_f_reg  <= first_sel;
                        op_k_reg  <= i_reg;
                        state_reg <= S_RM_RD;
                    end
                    else if (i_reg == TOP_O)
                    begin
                        state_reg <= S_FAIL;
                    end
                    else
                    begin
                        i_reg <= i_reg + OW'(1);
                    end
                end
                S_RM_RD:
                begin
                    state_reg <= S_RM_GOT;
                end
                S_RM_GOT:
                begin
                    ent_reg <= rd_ent;
                    if (rd_ent.prv == NONE_F)
                    begin
                        first_reg[lidx] <= rd_ent.nxt;
                        state_reg       <= S_RM_N;
                    end
                    else
                    begin
                        state_reg <= S_RM_PWR;
                    end
                end
                S_RM_PWR:
                begin
                    state_reg <= S_RM_N;
                end
                S_RM_N:
                begin
                    if (ent_reg.nxt == NONE_F)
                    begin
                        last_reg[lidx] <= ent_reg.prv;
                        state_reg      <= S_RM_F;
                    end
                    else
                    begin
                        state_reg <= S_RM_NWR;
                    end
                end
                S_RM_NWR:
                begin
                    state_reg <= S_RM_F;
                end
                S_RM_F:
                begin
                    state_reg <= (cmd_reg == CMD_ALLOC) ? S_SPLIT : S_MG_ABS;
                end
                S_SPLIT:
                begin
                    if (i_reg > k_reg)
                    begin
                        op_f_reg  <= buddy;
                        op_k_reg  <= i_reg - OW'(1);
                        i_reg     <= i_reg - OW'(1);
                        state_reg <= S_AP_W;
                    end
                    else
                    begin
                        state_reg <= S_SET_T;
                    end
                end
                S_SET_T:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= STATUS_OK;
                    rframe_reg <= FRAME_FIELD_W'(f_reg);
                    rorder_reg <= ORDER_FIELD_W'(k_reg);
                    state_reg  <= S_IDLE;
                end
                S_AP_W:
                begin
                    tail_reg       <= last_sel;
                    last_reg[lidx] <= op_f_reg;
                    if (last_sel == NONE_F)
                    begin
                        first_reg[lidx] <= op_f_reg;
                        state_reg       <= ret_state;
                    end
                    else
                    begin
                        state_reg <= S_AP_TWR;
                    end
                end
                S_AP_TWR:
                begin
                    state_reg <= ret_state;
                end
                S_FR_CHK:
                begin
                    if (rd_ent.fr || (32'(rd_ent.ord) > TOP_ORDER))
                    begin
                        state_reg <= S_FAIL;
                    end
                    else
                    begin
                        k_reg     <= rd_ent.ord;
                        state_reg <= S_MG_TEST;
                    end
                end
                S_MG_TEST:
                begin
                    if ((k_reg == TOP_O) || beyond)
                    begin
                        op_f_reg  <= f_reg;
                        op_k_reg  <= k_reg;
                        state_reg <= S_AP_W;
                    end
                    else
                    begin
                        state_reg <= S_MG_CHK;
                    end
                end
                S_MG_CHK:
                begin
                    if ((rd_ent.ord != k_reg) || !rd_ent.fr)
                    begin
                        op_f_reg  <= f_reg;
                        op_k_reg  <= k_reg;
                        state_reg <= S_AP_W;
                    end
                    else
                    begin
                        op_f_reg  <= buddy;
                        op_k_reg  <= k_reg;
                        state_reg <= S_RM_RD;
                    end
                end
                S_MG_ABS:
                begin
                    f_reg     <= lo;
                    k_reg     <= k_reg + OW'(1);
                    state_reg <= S_MG_TEST;
                end
                S_FR_DONE:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= STATUS_OK;
                    rframe_reg <= FRAME_FIELD_W'(f_reg);
                    rorder_reg <= ORDER_FIELD_W'(k_reg);
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_frame = rframe_reg;
    assign result_order = rorder_reg;

    `BPA_ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy)
    `BPA_ASSERT_IMPLIES(a_fail_zero, clk, rst_n, done && (status == STATUS_FAIL),
        (result_frame == '0) && (result_order == '0))
    `BPA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !done)
endmodule
`default_nettype wire
